// File: rtl/ngga_pkg.sv
`default_nettype none

package ngga_pkg;

  localparam int unsigned FRACTION_DIGITS = 4;
  localparam int unsigned STATUS_OFFSET   = 10;
  localparam int unsigned WIN_LEN         = STATUS_OFFSET + 2;
  localparam int unsigned FRAC_W          = 3;
  localparam int unsigned CNT_W           = 4;
  localparam int unsigned POS_W           = 3;
  localparam int unsigned POW_W           = 20;
  localparam int unsigned OUT_W           = 120;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_K      = 8'h4B;

  localparam logic [23:0] TYPE_GGA = 24'h474741;
  localparam logic [23:0] TYPE_TXT = 24'h545854;

  localparam logic KIND_GGA = 1'b0;
  localparam logic KIND_TXT = 1'b1;

  localparam logic [1:0] ANT_NONE    = 2'd0;
  localparam logic [1:0] ANT_OPEN    = 2'd1;
  localparam logic [1:0] ANT_OK      = 2'd2;
  localparam logic [1:0] ANT_SHORT   = 2'd3;

  localparam logic [CNT_W-1:0] COMMA_MAX   = 4'd15;
  localparam logic [CNT_W-1:0] COMMA_TIME  = 4'd1;
  localparam logic [CNT_W-1:0] COMMA_LAT   = 4'd2;
  localparam logic [CNT_W-1:0] COMMA_NS    = 4'd3;
  localparam logic [CNT_W-1:0] COMMA_LON   = 4'd4;
  localparam logic [CNT_W-1:0] COMMA_EW    = 4'd5;

  localparam logic [POS_W-1:0] POS_MAX       = 3'd7;
  localparam logic [POS_W-1:0] POS_TYPE_LO   = 3'd3;
  localparam logic [POS_W-1:0] POS_TYPE_HI   = 3'd5;

  typedef struct packed {
    logic [2:0]  val_we;
    logic [1:0]  hemi_we;
    logic [31:0] number;
    logic [7:0]  first_char;
  } fld_upd_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] code;
  } ant_hit_t;

  typedef struct packed {
    logic [1:0]  antenna;
    logic [7:0]  lon_hemi;
    logic [31:0] lon;
    logic [7:0]  lat_hemi;
    logic [31:0] lat;
    logic [31:0] utc;
  } report_t;

  function automatic logic [POW_W-1:0] pow10(input logic [FRAC_W-1:0] idx);
    logic [POW_W-1:0] r;
    unique case (idx)
      3'd0:    r = 20'd1;
      3'd1:    r = 20'd10;
      3'd2:    r = 20'd100;
      3'd3:    r = 20'd1000;
      3'd4:    r = 20'd10000;
      3'd5:    r = 20'd100000;
      default: r = 20'd1000000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/nmea_gga_txt_parser.sv
// Channel  Dir  tdata (low bit up)                                  tuser / tlast
// s_axis   in   rx_byte[7:0]                                        tlast: last_of_buffer
// m_axis   out  utc_time[31:0] latitude[63:32] lat_hemi[71:64]      tuser: sentence_kind
//               longitude[103:72] lon_hemi[111:104] antenna[113:112], zero pad to 120
//
// One byte is taken every cycle while s_axis_tready is high; the parse state, pending and
// committed values update at the accepting edge. A report is visible on m_axis the cycle
// after the closing '$' when the output register is free or drains at that edge; otherwise
// it waits in the skid. A two-entry output stage (register plus skid) holds reports;
// s_axis_tready drops only when both entries are full. Reset is immediate: no clearing pass.
`default_nettype none

module nmea_gga_txt_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // rx_byte[7:0]
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [ngga_pkg::OUT_W-1:0] m_axis_tdata,  // utc_time, latitude, latitude_hemisphere,
                                                    // longitude, longitude_hemisphere,
                                                    // antenna_status, zero pad
  output logic              m_axis_tuser    // sentence_kind
);
  import ngga_pkg::*;

  logic              acc, is_dollar, closing, is_gga, is_txt, push, pop, in_step;
  logic              in_sent_q;
  logic [7:0]        held_q;
  logic              held_vld_q;
  logic [POS_W-1:0]  pos_q, pos_n;
  logic [23:0]       type_q;
  logic [31:0]       pend_val_q [3];
  logic [7:0]        pend_hemi_q [2];
  logic [1:0]        pend_ant_q;
  report_t           comm_q, comm_d;
  fld_upd_t          upd;
  ant_hit_t          hit;

  report_t           out_q, skid_q;
  logic              out_kind_q, skid_kind_q;
  logic              out_vld_q, skid_vld_q;

  assign s_axis_tready = !skid_vld_q;
  assign acc       = s_axis_tvalid && s_axis_tready;
  assign is_dollar = (s_axis_tdata == CH_DOLLAR);
  assign in_step   = acc && !is_dollar && in_sent_q;
  assign closing   = acc && is_dollar && in_sent_q;
  assign is_gga    = (type_q == TYPE_GGA);
  assign is_txt    = (type_q == TYPE_TXT);
  assign push      = closing && (is_gga || is_txt);
  assign pop       = out_vld_q && m_axis_tready;
  assign pos_n     = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;

  ngga_field u_field (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (acc && is_dollar),
    .step_i  (in_step && held_vld_q),
    .byte_i  (held_q),
    .upd_o   (upd)
  );

  ngga_ant_scan u_ant (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (acc && is_dollar),
    .shift_i (in_step),
    .byte_i  (s_axis_tdata),
    .hit_o   (hit)
  );

  always_comb begin
    comm_d = comm_q;
    if (closing && is_gga) begin
      comm_d.utc      = pend_val_q[0];
      comm_d.lat      = pend_val_q[1];
      comm_d.lon      = pend_val_q[2];
      comm_d.lat_hemi = pend_hemi_q[0];
      comm_d.lon_hemi = pend_hemi_q[1];
    end
    if (closing && is_txt) comm_d.antenna = pend_ant_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_sent_q  <= 1'b0;
      held_q     <= '0;
      held_vld_q <= 1'b0;
      pos_q      <= '0;
      type_q     <= '0;
      for (int i = 0; i < 3; i++) pend_val_q[i] <= '0;
      for (int i = 0; i < 2; i++) pend_hemi_q[i] <= CH_ZERO;
      pend_ant_q <= ANT_NONE;
      comm_q     <= '{antenna: ANT_NONE, lon_hemi: CH_ZERO, lon: '0,
                      lat_hemi: CH_ZERO, lat: '0, utc: '0};
    end else if (acc) begin
      comm_q <= comm_d;
      if (is_dollar) begin
        in_sent_q      <= 1'b1;
        held_q         <= '0;
        held_vld_q     <= 1'b0;
        pos_q          <= '0;
        type_q         <= '0;
        pend_val_q[0]  <= comm_d.utc;
        pend_val_q[1]  <= comm_d.lat;
        pend_val_q[2]  <= comm_d.lon;
        pend_hemi_q[0] <= comm_d.lat_hemi;
        pend_hemi_q[1] <= comm_d.lon_hemi;
        pend_ant_q     <= comm_d.antenna;
      end else if (in_sent_q) begin
        held_q     <= s_axis_tdata;
        held_vld_q <= 1'b1;
        pos_q      <= pos_n;
        if (pos_n >= POS_TYPE_LO && pos_n <= POS_TYPE_HI) begin
          type_q <= {type_q[15:0], s_axis_tdata};
        end
        for (int i = 0; i < 3; i++) begin
          if (upd.val_we[i]) pend_val_q[i] <= upd.number;
        end
        for (int i = 0; i < 2; i++) begin
          if (upd.hemi_we[i]) pend_hemi_q[i] <= upd.first_char;
        end
        if (hit.hit) pend_ant_q <= hit.code;
      end
      if (s_axis_tlast) begin
        in_sent_q  <= 1'b0;
        held_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      skid_vld_q  <= 1'b0;
      out_q       <= '0;
      skid_q      <= '0;
      out_kind_q  <= KIND_GGA;
      skid_kind_q <= KIND_GGA;
    end else if (!out_vld_q || pop) begin
      out_vld_q  <= skid_vld_q || push;
      out_q      <= skid_vld_q ? skid_q : comm_d;
      out_kind_q <= skid_vld_q ? skid_kind_q : (is_gga ? KIND_GGA : KIND_TXT);
      skid_vld_q <= 1'b0;
    end else if (push) begin
      skid_q      <= comm_d;
      skid_kind_q <= is_gga ? KIND_GGA : KIND_TXT;
      skid_vld_q  <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {{(OUT_W - $bits(report_t)){1'b0}}, out_q};

endmodule

`default_nettype wire

// File: rtl/ngga_field.sv
`default_nettype none

module ngga_field (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             clear_i,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  output ngga_pkg::fld_upd_t    upd_o
);
  import ngga_pkg::*;

  logic [CNT_W-1:0]  comma_q, comma_d;
  logic              nonempty_q, nonempty_d;
  logic [31:0]       num_q, num_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic              dot_q, dot_d;
  logic              stop_q, stop_d;
  logic [7:0]        first_q, first_d;

  logic              is_digit;
  logic [35:0]       acc10;
  logic [FRAC_W-1:0] missing;
  logic [51:0]       scaled;
  logic [31:0]       finished;

  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign acc10    = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0} + {28'd0, byte_i - CH_ZERO};
  assign missing  = (frac_q < FRAC_W'(FRACTION_DIGITS)) ?
                    FRAC_W'(FRACTION_DIGITS) - frac_q : '0;
  assign scaled   = 52'(num_q) * 52'(pow10(missing));
  assign finished = (scaled[51:32] != '0) ? 32'hFFFF_FFFF : scaled[31:0];

  always_comb begin
    comma_d    = comma_q;
    nonempty_d = nonempty_q;
    num_d      = num_q;
    frac_d     = frac_q;
    dot_d      = dot_q;
    stop_d     = stop_q;
    first_d    = first_q;
    upd_o      = '0;
    upd_o.number     = finished;
    upd_o.first_char = first_q;
    if (clear_i) begin
      comma_d    = '0;
      nonempty_d = 1'b0;
      num_d      = '0;
      frac_d     = '0;
      dot_d      = 1'b0;
      stop_d     = 1'b0;
      first_d    = '0;
    end else if (step_i) begin
      if (byte_i == CH_COMMA) begin
        if (nonempty_q) begin
          unique case (comma_q)
            COMMA_TIME: upd_o.val_we[0]  = 1'b1;
            COMMA_LAT:  upd_o.val_we[1]  = 1'b1;
            COMMA_NS:   upd_o.hemi_we[0] = 1'b1;
            COMMA_LON:  upd_o.val_we[2]  = 1'b1;
            COMMA_EW:   upd_o.hemi_we[1] = 1'b1;
            default:    ;
          endcase
        end
        if (comma_q != COMMA_MAX) comma_d = comma_q + 1'b1;
        nonempty_d = 1'b0;
        num_d      = '0;
        frac_d     = '0;
        dot_d      = 1'b0;
        stop_d     = 1'b0;
        first_d    = '0;
      end else begin
        if (!nonempty_q) begin
          nonempty_d = 1'b1;
          first_d    = byte_i;
        end
        if (!stop_q) begin
          if (is_digit) begin
            if (!(dot_q && frac_q >= FRAC_W'(FRACTION_DIGITS))) begin
              num_d = (acc10[35:32] != '0) ? 32'hFFFF_FFFF : acc10[31:0];
              if (dot_q) frac_d = frac_q + 1'b1;
            end
          end else if (byte_i == CH_DOT && !dot_q) begin
            dot_d = 1'b1;
          end else begin
            stop_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comma_q    <= '0;
      nonempty_q <= 1'b0;
      num_q      <= '0;
      frac_q     <= '0;
      dot_q      <= 1'b0;
      stop_q     <= 1'b0;
      first_q    <= '0;
    end else begin
      comma_q    <= comma_d;
      nonempty_q <= nonempty_d;
      num_q      <= num_d;
      frac_q     <= frac_d;
      dot_q      <= dot_d;
      stop_q     <= stop_d;
      first_q    <= first_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ngga_ant_scan.sv
`default_nettype none

module ngga_ant_scan (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           clear_i,
  input  wire logic           shift_i,
  input  wire logic [7:0]     byte_i,
  output ngga_pkg::ant_hit_t  hit_o
);
  import ngga_pkg::*;

  logic [7:0] win_q [WIN_LEN];
  logic [7:0] win_d [WIN_LEN];

  always_comb begin
    win_d[0] = byte_i;
    for (int i = 1; i < WIN_LEN; i++) begin
      win_d[i] = win_q[i-1];
    end
  end

  always_comb begin
    hit_o.hit  = shift_i && (win_d[STATUS_OFFSET+1] == CH_A) &&
                 (win_d[STATUS_OFFSET] == CH_N) && (win_d[STATUS_OFFSET-1] == CH_T);
    if (win_d[1] == CH_O && win_d[0] == CH_P) begin
      hit_o.code = ANT_OPEN;
    end else if (win_d[1] == CH_O && win_d[0] == CH_K) begin
      hit_o.code = ANT_OK;
    end else begin
      hit_o.code = ANT_SHORT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_LEN; i++) win_q[i] <= '0;
    end else if (clear_i) begin
      for (int i = 0; i < WIN_LEN; i++) win_q[i] <= '0;
    end else if (shift_i) begin
      for (int i = 0; i < WIN_LEN; i++) win_q[i] <= win_d[i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/ngga_checker.sv
`default_nettype none

module ngga_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tvalid,
  input wire logic                       s_axis_tready,
  input wire logic [7:0]                 s_axis_tdata,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [ngga_pkg::OUT_W-1:0] m_axis_tdata,
  input wire logic                       m_axis_tuser
);
  import ngga_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("report changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready
      && s_axis_tdata == CH_DOLLAR))
    else $error("report without a closing dollar beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_W-1:$bits(report_t)] == '0)
    else $error("pad bits set");

endmodule

bind nmea_gga_txt_parser ngga_checker u_ngga_checker (.*);

`default_nettype wire

// File: sim/tb_nmea_gga_txt_parser.sv
`default_nettype none

module tb_nmea_gga_txt_parser;
  import ngga_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned PHASE_BYTES  = 110;
  localparam int unsigned PHASE_CLOSED = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } rx_beat_t;

  typedef struct {
    logic    kind;
    report_t rep;
  } nmea_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // rx_byte[7:0]
  logic                s_axis_tlast = 1'b0; // last_of_buffer
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;        // utc_time, latitude, latitude_hemisphere,
                                            // longitude, longitude_hemisphere, antenna_status
  logic                m_axis_tuser;        // sentence_kind

  nmea_gga_txt_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  rx_beat_t     rx_items[$];
  logic [7:0]   sentence_q[$];
  nmea_report_t owed_reports[$];
  string        hemi_letters = "NSEW";

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned queued_bytes = 0;
  int unsigned closable_count = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic        byte_taken = 1'b0;

  // Parser state mirror
  logic                    in_frame = 1'b0;
  logic [7:0]              held_char = '0;
  logic                    held_ok = 1'b0;
  logic [POS_W-1:0]        char_pos = '0;
  logic [23:0]             type_code = '0;
  logic [CNT_W-1:0]        commas = '0;
  logic                    field_seen = 1'b0;
  logic [31:0]             field_val = '0;
  int unsigned             frac_digits = 0;
  logic                    dot_seen = 1'b0;
  logic                    num_halted = 1'b0;
  logic [7:0]              field_lead = '0;
  logic [7:0]              ant_window[WIN_LEN] = '{default: 8'h00};
  logic [31:0]             staged_val[3] = '{default: 32'h0};
  logic [7:0]              staged_hemi[2] = '{CH_ZERO, CH_ZERO};
  logic [1:0]              staged_ant = ANT_NONE;
  logic [31:0]             fix_val[3] = '{default: 32'h0};
  logic [7:0]              fix_hemi[2] = '{CH_ZERO, CH_ZERO};
  logic [1:0]              fix_ant = ANT_NONE;

  function automatic logic [31:0] scaled_field();
    int unsigned     pad;
    longint unsigned v;
    pad = (frac_digits < FRACTION_DIGITS) ? FRACTION_DIGITS - frac_digits : 0;
    if (pad > 6) pad = 6;
    v = 64'(field_val);
    repeat (pad) v = v * 10;
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
  endfunction

  task automatic clear_field();
    field_seen  = 1'b0;
    field_val   = '0;
    frac_digits = 0;
    dot_seen    = 1'b0;
    num_halted  = 1'b0;
    field_lead  = '0;
  endtask

  task automatic field_step(input logic [7:0] c);
    longint unsigned acc;
    if (c == CH_COMMA) begin
      if (field_seen) begin
        case (commas)
          COMMA_TIME: staged_val[0]  = scaled_field();
          COMMA_LAT:  staged_val[1]  = scaled_field();
          COMMA_NS:   staged_hemi[0] = field_lead;
          COMMA_LON:  staged_val[2]  = scaled_field();
          COMMA_EW:   staged_hemi[1] = field_lead;
          default: ;
        endcase
      end
      if (commas < COMMA_MAX) commas++;
      clear_field();
    end else begin
      if (!field_seen) begin
        field_seen = 1'b1;
        field_lead = c;
      end
      if (!num_halted) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          if (!(dot_seen && frac_digits >= FRACTION_DIGITS)) begin
            acc = longint'(field_val) * 10 + longint'(c - CH_ZERO);
            field_val = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(acc);
            if (dot_seen) frac_digits++;
          end
        end else if (c == CH_DOT && !dot_seen) begin
          dot_seen = 1'b1;
        end else begin
          num_halted = 1'b1;
        end
      end
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    nmea_report_t r;
    logic         owe;
    owe = 1'b0;
    if (b == CH_DOLLAR) begin
      if (in_frame) begin
        if (type_code == TYPE_GGA) begin
          fix_val  = staged_val;
          fix_hemi = staged_hemi;
          r.kind   = KIND_GGA;
          owe      = 1'b1;
        end else if (type_code == TYPE_TXT) begin
          fix_ant = staged_ant;
          r.kind  = KIND_TXT;
          owe     = 1'b1;
        end
        if (owe) begin
          r.rep.utc      = fix_val[0];
          r.rep.lat      = fix_val[1];
          r.rep.lat_hemi = fix_hemi[0];
          r.rep.lon      = fix_val[2];
          r.rep.lon_hemi = fix_hemi[1];
          r.rep.antenna  = fix_ant;
          owed_reports.push_back(r);
        end
      end
      in_frame  = 1'b1;
      held_ok   = 1'b0;
      held_char = '0;
      char_pos  = '0;
      type_code = '0;
      commas    = '0;
      clear_field();
      for (int i = 0; i < WIN_LEN; i++) ant_window[i] = 8'h00;
      staged_val  = fix_val;
      staged_hemi = fix_hemi;
      staged_ant  = fix_ant;
    end else if (in_frame) begin
      if (held_ok) field_step(held_char);
      held_char = b;
      held_ok   = 1'b1;
      if (char_pos < POS_MAX) char_pos++;
      if (char_pos >= POS_TYPE_LO && char_pos <= POS_TYPE_HI) type_code = {type_code[15:0], b};
      for (int i = WIN_LEN - 1; i > 0; i--) ant_window[i] = ant_window[i-1];
      ant_window[0] = b;
      if (ant_window[STATUS_OFFSET+1] == CH_A && ant_window[STATUS_OFFSET] == CH_N &&
          ant_window[STATUS_OFFSET-1] == CH_T) begin
        if (ant_window[1] == CH_O && ant_window[0] == CH_P) staged_ant = ANT_OPEN;
        else if (ant_window[1] == CH_O && ant_window[0] == CH_K) staged_ant = ANT_OK;
        else staged_ant = ANT_SHORT;
      end
    end
    if (last) begin
      in_frame = 1'b0;
      held_ok  = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    report_t      got;
    nmea_report_t want;
    if (rst_ni) begin
      byte_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got = report_t'(m_axis_tdata[$bits(report_t)-1:0]);
        if (owed_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected report beat: %h", m_axis_tdata);
        end else begin
          want = owed_reports.pop_front();
          check_field("sentence_kind", 32'(want.kind), 32'(m_axis_tuser));
          check_field("utc_time", want.rep.utc, got.utc);
          check_field("latitude", want.rep.lat, got.lat);
          check_field("latitude_hemisphere", 32'(want.rep.lat_hemi), 32'(got.lat_hemi));
          check_field("longitude", want.rep.lon, got.lon);
          check_field("longitude_hemisphere", 32'(want.rep.lon_hemi), 32'(got.lon_hemi));
          check_field("antenna_status", 32'(want.rep.antenna), 32'(got.antenna));
          check_field("pad", 32'd0, 32'(m_axis_tdata[OUT_W-1:$bits(report_t)]));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin : driver
    if (byte_taken) void'(rx_items.pop_front());
    if (!s_axis_tvalid || byte_taken) begin
      if (rx_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_items[0].data;
        s_axis_tlast  <= rx_items[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    if (hold_off_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_off_cycles = hold_off_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    rx_items.push_back({b, last});
    queued_bytes++;
  endtask

  task automatic append_text(input string t);
    for (int i = 0; i < t.len(); i++) sentence_q.push_back(t[i]);
  endtask

  task automatic append_filler(input int unsigned n, input logic [7:0] banned);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_DOLLAR || b == banned);
      sentence_q.push_back(b);
    end
  endtask

  task automatic flush_sentence(input int drop_pos);
    for (int i = 0; i < sentence_q.size(); i++) push_byte(sentence_q[i], i == drop_pos);
    sentence_q.delete();
  endtask

  task automatic send_text(input string t, input bit last_at_end);
    append_text(t);
    flush_sentence(last_at_end ? sentence_q.size() - 1 : -1);
  endtask

  task automatic add_sentence();
    int unsigned roll;
    int unsigned pick;
    int          drop_pos;
    sentence_q.push_back(CH_DOLLAR);
    repeat (2) sentence_q.push_back(CH_A + 8'($urandom_range(0, 25)));
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      append_text("GGA");
      repeat ($urandom_range(0, 9)) begin
        sentence_q.push_back(CH_COMMA);
        pick = $urandom_range(0, 99);
        if (pick >= 20 && pick < 45) begin
          sentence_q.push_back(hemi_letters[$urandom_range(0, 3)]);
        end else if (pick >= 45 && pick < 90) begin
          repeat (($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4))
            sentence_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 9) < 6) begin
            sentence_q.push_back(CH_DOT);
            repeat ($urandom_range(0, 6)) sentence_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          end
          if ($urandom_range(0, 9) < 2) append_filler(1, CH_COMMA);
        end else if (pick >= 90) begin
          append_filler($urandom_range(1, 3), CH_COMMA);
        end
      end
    end else if (roll < 80) begin
      append_text("TXT");
      append_filler($urandom_range(0, 6), CH_DOLLAR);
      if ($urandom_range(0, 99) < 75) begin
        append_text("ANT");
        // misalign now and then
        append_filler(STATUS_OFFSET - 3 + (($urandom_range(0, 9) == 0) ? 1 : 0), CH_DOLLAR);
        pick = $urandom_range(0, 2);
        if (pick == 0) append_text("OP");
        else if (pick == 1) append_text("OK");
        else append_filler(2, CH_DOLLAR);
      end
      append_filler($urandom_range(0, 3), CH_DOLLAR);
    end else if (roll < 90) begin
      append_text("RMC,1,2");
    end else begin
      append_filler($urandom_range(0, 4), CH_DOLLAR);
    end
    drop_pos = ($urandom_range(0, 99) < 8) ? $urandom_range(0, sentence_q.size() - 1) : -1;
    if (roll < 80 && drop_pos < 0) closable_count++;
    flush_sentence(drop_pos);
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic drain_reports();
    while (rx_items.size() != 0 || s_axis_tvalid || owed_reports.size() != 0) @(posedge clk_i);
  endtask

  int unsigned src_pct_tab[4] = '{0, 53, 0, 34};
  int unsigned snk_pct_tab[4] = '{0, 0, 53, 34};

  initial begin
    int unsigned start_bytes;
    int unsigned start_closed;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // outside any sentence: ignore
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    send_text("$GPGGA,99999999999.9,.12345,N,12.3.4,W,", 1'b0);
    send_text("$GPTXT,ANT1234567OK", 1'b0);
    send_text("$GPTXT,ANT1234567OP", 1'b0);
    send_text("$GNTXTANTabcdefgZZ", 1'b0);
    send_text("$G", 1'b0);
    send_text("$GPGGA,235959,4807.038,S,01131,E,", 1'b0);
    send_text("$GPGGA,1,2,N,3,W,", 1'b1);
    send_text("$GPGGA,,,,,,,", 1'b0);
    send_text("$", 1'b1);
    send_text("$GPGGA,5,6,N,7,E,", 1'b0);
    send_text("$", 1'b0);
    drain_reports();

    // stall the output long enough to back up the input
    hold_off_cycles = 400;
    repeat (4) send_text("$GPGGA,1,2,N,3,E,", 1'b0);
    send_text("$", 1'b0);
    drain_reports();

    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = src_pct_tab[p];
      snk_stall_pct = snk_pct_tab[p];
      start_bytes   = queued_bytes;
      start_closed  = closable_count;
      while (queued_bytes - start_bytes < PHASE_BYTES || closable_count - start_closed < PHASE_CLOSED)
        add_sentence();
      send_text("$", 1'b0);
      drain_reports();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && owed_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/ngga_pkg.sv
rtl/ngga_field.sv
rtl/ngga_ant_scan.sv
rtl/nmea_gga_txt_parser.sv
rtl/ngga_checker.sv
sim/tb_nmea_gga_txt_parser.sv
